// ===== design/motor_encoder_feedback_tracker_top_assert.svh =====
// assertion macros for the multi-turn encoder tracker
// needs clk_i and rst_ni in the scope of every use
`ifndef MOTOR_ENCODER_FEEDBACK_TRACKER_TOP_ASSERT_SVH
`define MOTOR_ENCODER_FEEDBACK_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTH
// checked outside reset
`define METR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked during reset too
`define METR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define METR_ASSERT(lbl, prop, msg)
`define METR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== design/metr_pkg.sv =====
// shared types and constants of the multi-turn encoder tracker
// no dependencies
package metr_pkg;

  // field widths
  localparam int unsigned FRAME_ID_W = 11;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned SPEED_W    = 17;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CAL_W      = 6;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DELTA_W    = 18;
  localparam int unsigned MIDX_W     = 2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_CNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd2;

  localparam logic [FRAME_ID_W-1:0] BASE_ID_RST = 11'd513;
  localparam logic [CAL_W-1:0]      CAL_CNT_RST = 6'd50;
  localparam logic [GAIN_W-1:0]     GAIN_RST    = 16'd5356;

  localparam logic [CAL_W-1:0]   CTR_MAX    = 6'd63;
  localparam logic [ANGLE_W-1:0] SPEED_HALF = 16'd32768;

  // default sizing
  localparam int unsigned NUM_MOTORS_DEF = 4;
  localparam int unsigned RING_DEPTH_DEF = 30;
  localparam int unsigned SUM_TAPS_DEF   = 28;
  localparam int unsigned TURN_RANGE_DEF = 8192;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WRAP,
    S_POS,
    S_DELTA,
    S_SUM,
    S_DRAIN,
    S_MUL,
    S_SCALE,
    S_OUT
  } metr_state_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic wrap;
    logic pos;
    logic delta;
    logic sum_issue;
    logic mul;
    logic scale;
    logic load_out;
  } metr_cmd_t;

  typedef struct packed {
    logic hit;
    logic calib;
    logic ring_done;
    logic last_tap;
    logic out_free;
  } metr_sts_t;

endpackage

// ===== design/metr_if.sv =====
// request channels of the encoder tracker: feedback frame in, result out
// no dependencies
interface metr_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] frame_id;
  logic [15:0] angle_raw;
  logic [15:0] speed_raw;

  modport source (output valid, frame_id, angle_raw, speed_raw, input ready);
  modport sink   (input valid, frame_id, angle_raw, speed_raw, output ready);
endinterface

interface metr_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         motor_sel;
  logic               calibrating;
  logic signed [16:0] speed;
  logic signed [31:0] turn_count;
  logic signed [31:0] position;
  logic signed [31:0] angular_rate;

  modport source (output valid, motor_sel, calibrating, speed, turn_count, position,
                  angular_rate, input ready);
  modport sink   (input valid, motor_sel, calibrating, speed, turn_count, position,
                  angular_rate, output ready);
endinterface

// ===== design/metr_ctrl.sv =====
// sequencer of the encoder tracker: walks one request through the datapath
// depends on metr_pkg and the assertion macro header
`include "motor_encoder_feedback_tracker_top_assert.svh"

module metr_ctrl import metr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  metr_sts_t sts_i,
  output metr_cmd_t cmd_o
);

  metr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        if (!sts_i.hit) begin
          state_d = S_IDLE;
        end else if (sts_i.calib) begin
          state_d = S_OUT;
        end else begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = S_POS;
      end
      S_POS: begin
        cmd_o.pos = 1'b1;
        state_d   = S_DELTA;
      end
      S_DELTA: begin
        cmd_o.delta = 1'b1;
        state_d     = sts_i.ring_done ? S_SUM : S_OUT;
      end
      S_SUM: begin
        cmd_o.sum_issue = 1'b1;
        if (sts_i.last_tap) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  `METR_ASSERT(a_load_free, cmd_o.load_out |-> sts_i.out_free, "result loaded over a held one")
  `METR_ASSERT(a_sum_entry, (state_q == S_SUM) |-> ($past(state_q) == S_DELTA || $past(state_q) == S_SUM), "summing walk entered out of order")
  `METR_ASSERT(a_decode_after_req, (state_q == S_DECODE) |-> $past(in_valid_i && in_ready_o), "decode without an accepted request")

endmodule

// ===== design/metr_dp.sv =====
// datapath of the encoder tracker: config, per-motor state, delta ring,
// summing accumulator and rate multiplier; depends on metr_pkg and the macro header
`include "motor_encoder_feedback_tracker_top_assert.svh"

module metr_dp import metr_pkg::*; #(
  parameter int unsigned NUM_MOTORS = NUM_MOTORS_DEF,
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned SUM_TAPS   = SUM_TAPS_DEF,
  parameter int unsigned TURN_RANGE = TURN_RANGE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [FRAME_ID_W-1:0]    frame_id_i,
  input  logic [ANGLE_W-1:0]       angle_raw_i,
  input  logic [ANGLE_W-1:0]       speed_raw_i,
  input  metr_cmd_t                cmd_i,
  output metr_sts_t                sts_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [MIDX_W-1:0]        motor_sel_o,
  output logic                     calibrating_o,
  output logic signed [SPEED_W-1:0] speed_o,
  output logic signed [WORD_W-1:0] turn_count_o,
  output logic signed [WORD_W-1:0] position_o,
  output logic signed [WORD_W-1:0] angular_rate_o
);

  localparam int unsigned MW       = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int unsigned ENTRIES  = NUM_MOTORS * RING_DEPTH;
  localparam int unsigned AW       = $clog2(ENTRIES);
  localparam int unsigned IW       = $clog2(RING_DEPTH);
  localparam int unsigned TAPS_EFF = (SUM_TAPS > RING_DEPTH) ? RING_DEPTH : SUM_TAPS;
  localparam int unsigned TW       = (TAPS_EFF > 1) ? $clog2(TAPS_EFF) : 1;
  localparam int unsigned ACC_W    = DELTA_W + $clog2(TAPS_EFF + 1);
  localparam int unsigned PW       = ACC_W + GAIN_W + 1;
  localparam int unsigned RW       = PW - 16;

  localparam logic [WORD_W-1:0]       TURN_K    = WORD_W'(TURN_RANGE);
  localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(TURN_RANGE / 2);
  localparam logic [IW-1:0]           IDX_LAST  = IW'(RING_DEPTH - 1);
  localparam logic [TW-1:0]           TAP_LAST  = TW'(TAPS_EFF - 1);

  // configuration
  logic [FRAME_ID_W-1:0] base_id_q;
  logic [CAL_W-1:0]      cal_cnt_q;
  logic [GAIN_W-1:0]     gain_q;

  // captured request
  logic [FRAME_ID_W-1:0] id_q;
  logic [ANGLE_W-1:0]    ang_q;
  logic [ANGLE_W-1:0]    sraw_q;

  // per-motor state
  logic [CAL_W-1:0]   fcnt_q     [NUM_MOTORS];
  logic [ANGLE_W-1:0] offset_q   [NUM_MOTORS];
  logic [ANGLE_W-1:0] prev_raw_q [NUM_MOTORS];
  logic [WORD_W-1:0]  wrap_q     [NUM_MOTORS];
  logic [WORD_W-1:0]  prev_pos_q [NUM_MOTORS];
  logic [IW-1:0]      ring_idx_q [NUM_MOTORS];
  logic [WORD_W-1:0]  held_q     [NUM_MOTORS];

  // working registers
  logic [MW-1:0]             m_q;
  logic                      cal_q;
  logic [AW-1:0]             base_q;
  logic [SPEED_W-1:0]        spd_q;
  logic [WORD_W-1:0]         pos_q;
  logic [TW-1:0]             tap_q;
  logic                      rd_vld_q;
  logic [DELTA_W-1:0]        rd_data_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PW-1:0]      prod_q;

  // delta ring memory
  logic [DELTA_W-1:0] ring_mem [ENTRIES];

  // output register
  logic                     out_vld_q;
  logic [MIDX_W-1:0]        out_mi_q;
  logic                     out_cal_q;
  logic [SPEED_W-1:0]       out_spd_q;
  logic [WORD_W-1:0]        out_turn_q;
  logic [WORD_W-1:0]        out_pos_q;
  logic [WORD_W-1:0]        out_rate_q;

  logic [FRAME_ID_W-1:0]    m11;
  logic [MW-1:0]            mi;
  logic                     hit;
  logic                     calib;
  logic signed [DELTA_W-1:0] diff;
  logic [WORD_W-1:0]        wrap_d;
  logic [WORD_W-1:0]        pos_d;
  logic [WORD_W-1:0]        delta;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;
  logic signed [PW-1:0]     prod_adj;
  logic [RW-1:0]            rate_hi;
  logic [WORD_W-1:0]        rate_d;
  logic [FRAME_ID_W-1:0]    m_ext;
  logic [SPEED_W-1:0]       spd_d;

  // motor decode and calibration test
  assign m11   = id_q - base_id_q;
  assign hit   = m11 < FRAME_ID_W'(NUM_MOTORS);
  assign mi    = m11[MW-1:0];
  assign calib = fcnt_q[mi] < cal_cnt_q;
  assign spd_d = (sraw_q > SPEED_HALF) ? {1'b1, sraw_q} : {1'b0, sraw_q};

  // wrap detection on the raw angle jump
  assign diff = $signed({2'b00, ang_q}) - $signed({2'b00, prev_raw_q[m_q]});
  always_comb begin
    wrap_d = wrap_q[m_q];
    if (diff > HALF_TURN) begin
      wrap_d = wrap_q[m_q] - 32'd1;
    end else if (diff < -HALF_TURN) begin
      wrap_d = wrap_q[m_q] + 32'd1;
    end
  end

  assign pos_d   = WORD_W'(ang_q) + WORD_W'(TURN_K * wrap_q[m_q]) - WORD_W'(offset_q[m_q]);
  assign delta   = pos_q - prev_pos_q[m_q];
  assign wr_addr = base_q + AW'(ring_idx_q[m_q]);
  assign rd_addr = base_q + AW'(tap_q);

  // truncate toward zero: bias negative products before the shift
  assign prod_adj = prod_q + (prod_q[PW-1] ? PW'(16'hFFFF) : PW'(0));
  assign rate_hi  = prod_adj[PW-1:16];
  assign rate_d   = {{(WORD_W-RW){rate_hi[RW-1]}}, rate_hi};

  assign m_ext = FRAME_ID_W'(m_q);

  always_comb begin
    sts_o           = '0;
    sts_o.hit       = hit;
    sts_o.calib     = calib;
    sts_o.ring_done = ring_idx_q[m_q] == IDX_LAST;
    sts_o.last_tap  = tap_q == TAP_LAST;
    sts_o.out_free  = !out_vld_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_id_q <= BASE_ID_RST;
      cal_cnt_q <= CAL_CNT_RST;
      gain_q    <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_ID: base_id_q <= cfg_wdata_i[FRAME_ID_W-1:0];
        CFG_CAL_CNT: cal_cnt_q <= cfg_wdata_i[CAL_W-1:0];
        CFG_GAIN:    gain_q    <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // per-motor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        fcnt_q[i]     <= '0;
        offset_q[i]   <= '0;
        prev_raw_q[i] <= '0;
        wrap_q[i]     <= '0;
        prev_pos_q[i] <= '0;
        ring_idx_q[i] <= '0;
        held_q[i]     <= '0;
      end
    end else begin
      if (cmd_i.decode && hit) begin
        if (fcnt_q[mi] < CTR_MAX) begin
          fcnt_q[mi] <= fcnt_q[mi] + 6'd1;
        end
        if (calib) begin
          offset_q[mi]   <= ang_q;
          prev_raw_q[mi] <= ang_q;
          prev_pos_q[mi] <= WORD_W'(ang_q);
        end
      end
      if (cmd_i.wrap) begin
        wrap_q[m_q]     <= wrap_d;
        prev_raw_q[m_q] <= ang_q;
      end
      if (cmd_i.delta) begin
        prev_pos_q[m_q] <= pos_q;
        ring_idx_q[m_q] <= (ring_idx_q[m_q] == IDX_LAST) ? '0 : ring_idx_q[m_q] + IW'(1);
      end
      if (cmd_i.scale) begin
        held_q[m_q] <= rate_d;
      end
    end
  end

  // request capture and working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      id_q   <= frame_id_i;
      ang_q  <= angle_raw_i;
      sraw_q <= speed_raw_i;
    end
    if (cmd_i.decode) begin
      m_q    <= mi;
      cal_q  <= calib;
      base_q <= AW'(mi * RING_DEPTH);
      spd_q  <= spd_d;
    end
    if (cmd_i.pos) begin
      pos_q <= pos_d;
    end
    if (cmd_i.delta) begin
      tap_q <= '0;
      acc_q <= '0;
    end else begin
      if (cmd_i.sum_issue) begin
        tap_q <= tap_q + TW'(1);
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + {{(ACC_W-DELTA_W){rd_data_q[DELTA_W-1]}}, rd_data_q};
      end
    end
    if (cmd_i.mul) begin
      prod_q <= acc_q * $signed({1'b0, gain_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.sum_issue;
    end
  end

  // ring memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.delta) begin
      ring_mem[wr_addr] <= delta[DELTA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_issue) begin
      rd_data_q <= ring_mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mi_q  <= m_ext[MIDX_W-1:0];
      out_cal_q <= cal_q;
      if (cal_q) begin
        out_spd_q  <= '0;
        out_turn_q <= '0;
        out_pos_q  <= '0;
        out_rate_q <= '0;
      end else begin
        out_spd_q  <= spd_q;
        out_turn_q <= wrap_q[m_q];
        out_pos_q  <= pos_q;
        out_rate_q <= held_q[m_q];
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign motor_sel_o    = out_mi_q;
  assign calibrating_o  = out_cal_q;
  assign speed_o        = $signed(out_spd_q);
  assign turn_count_o   = $signed(out_turn_q);
  assign position_o     = $signed(out_pos_q);
  assign angular_rate_o = $signed(out_rate_q);

  `METR_ASSERT(a_out_rise, $rose(out_vld_q) |-> $past(cmd_i.load_out), "result shown without a load")
  `METR_ASSERT(a_cal_zero, (out_vld_q && out_cal_q) |-> (out_pos_q == '0 && out_rate_q == '0 && out_turn_q == '0), "calibration result carries data")
  `METR_ASSERT(a_ring_range, cmd_i.delta |-> (32'(ring_idx_q[m_q]) < RING_DEPTH), "ring index beyond depth")
  `METR_ASSERT_RST(a_rst_out, !rst_ni |-> !out_vld_q, "result valid during reset")

endmodule

// ===== design/motor_encoder_feedback_tracker_top.sv =====
// one frame at a time; a tracked frame goes decode, unwrap, position, delta,
//   output; calibration frames go decode, output; unknown ids end after decode
//   with no result; a ring-closing frame also sums min(SUM_TAPS, RING_DEPTH) taps
//   from the single-read-port delta ring memory, then multiplies and scales
// reset: asynchronous, active low; config, sequencer state and result valid take
//   defaults, per-motor tracking state clears at once; ring memory is not cleared
module motor_encoder_feedback_tracker_top import metr_pkg::*; #(
  parameter int unsigned NUM_MOTORS = NUM_MOTORS_DEF,
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned SUM_TAPS   = SUM_TAPS_DEF,
  parameter int unsigned TURN_RANGE = TURN_RANGE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes, only while no request is in flight
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // feedback frame requests
  metr_in_if.sink               in_chan,
  // tracking result requests
  metr_out_if.source            out_chan
);

  metr_cmd_t cmd;
  metr_sts_t sts;
  logic      in_ready;

  // sequencer: one frame at a time, decode, unwrap, position, delta, optional sum
  metr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_chan.ready = in_ready;

  // datapath: output register lets the next frame start while a result waits
  metr_dp #(
    .NUM_MOTORS (NUM_MOTORS),
    .RING_DEPTH (RING_DEPTH),
    .SUM_TAPS   (SUM_TAPS),
    .TURN_RANGE (TURN_RANGE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .frame_id_i     (in_chan.frame_id),
    .angle_raw_i    (in_chan.angle_raw),
    .speed_raw_i    (in_chan.speed_raw),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_chan.valid),
    .out_ready_i    (out_chan.ready),
    .motor_sel_o    (out_chan.motor_sel),
    .calibrating_o  (out_chan.calibrating),
    .speed_o        (out_chan.speed),
    .turn_count_o   (out_chan.turn_count),
    .position_o     (out_chan.position),
    .angular_rate_o (out_chan.angular_rate)
  );

endmodule

// ===== sim/tb_motor_encoder_feedback_tracker_top.sv =====
// testbench of the multi-turn encoder tracker: feedback frames in, tracking results out
// depends on metr_pkg, the channel interfaces of metr_if.sv and motor_encoder_feedback_tracker_top
// an in-bench predictor follows every accepted frame and checks each result in order
module tb_motor_encoder_feedback_tracker_top;
  import metr_pkg::*;

  // sizing of the block under test, taken from the package defaults
  localparam int unsigned MOTORS = NUM_MOTORS_DEF;
  localparam int unsigned DEPTH  = RING_DEPTH_DEF;
  localparam int unsigned TAPS   =
    (SUM_TAPS_DEF > RING_DEPTH_DEF) ? RING_DEPTH_DEF : SUM_TAPS_DEF;
  localparam int unsigned TURN   = TURN_RANGE_DEF;

  // long enough to cover any work still in flight, also the tap walk of a ring-closing frame
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    logic [FRAME_ID_W-1:0] frame_id;
    logic [ANGLE_W-1:0]    angle_raw;
    logic [ANGLE_W-1:0]    speed_raw;
  } frame_t;

  typedef struct packed {
    logic [MIDX_W-1:0]         motor_sel;
    logic                      calibrating;
    logic signed [SPEED_W-1:0] speed;
    logic signed [WORD_W-1:0]  turn_count;
    logic signed [WORD_W-1:0]  position;
    logic signed [WORD_W-1:0]  angular_rate;
  } track_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // per-motor tracking predictor plus the store of results still owed by the block
  class tracker_scoreboard;
    logic [FRAME_ID_W-1:0] base_id;
    logic [CAL_W-1:0]      cal_frames;
    logic [GAIN_W-1:0]     gain;

    logic [CAL_W-1:0]   frame_cnt  [MOTORS];
    logic [ANGLE_W-1:0] zero_ofs   [MOTORS];
    logic [ANGLE_W-1:0] last_angle [MOTORS];
    logic [WORD_W-1:0]  turns      [MOTORS];
    logic [WORD_W-1:0]  last_pos   [MOTORS];
    logic [WORD_W-1:0]  held_rate  [MOTORS];
    int unsigned        ring_wr    [MOTORS];
    logic [DELTA_W-1:0] deltas     [MOTORS][DEPTH];

    track_t expected_tracks[$];

    int errors      = 0;
    int frames      = 0;
    int foreign     = 0;
    int checked     = 0;
    int cal_results = 0;
    int windows     = 0;
    int wraps       = 0;

    function new();
      base_id    = BASE_ID_RST;
      cal_frames = CAL_CNT_RST;
      gain       = GAIN_RST;
      for (int m = 0; m < MOTORS; m++) begin
        frame_cnt[m]  = '0;
        zero_ofs[m]   = '0;
        last_angle[m] = '0;
        turns[m]      = '0;
        last_pos[m]   = '0;
        held_rate[m]  = '0;
        ring_wr[m]    = 0;
        for (int i = 0; i < DEPTH; i++) deltas[m][i] = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE_ID: base_id = data[FRAME_ID_W-1:0];
        CFG_CAL_CNT: cal_frames = data[CAL_W-1:0];
        CFG_GAIN:    gain = data[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    // sum of the first taps, scaled by the Q16 gain, truncated toward zero
    function logic [WORD_W-1:0] window_rate(int unsigned m);
      longint      sum;
      longint      prod;
      logic [63:0] mag;
      sum = 0;
      for (int i = 0; i < TAPS; i++) sum += longint'($signed(deltas[m][i]));
      prod = sum * longint'(gain);
      mag = (prod < 0) ? 64'(-prod) : 64'(prod);
      mag = mag >> 16;
      return (prod < 0) ? -mag[WORD_W-1:0] : mag[WORD_W-1:0];
    endfunction

    function void note_frame(frame_t f);
      logic [FRAME_ID_W-1:0] slot;
      int unsigned           m;
      logic                  cal;
      int                    diff;
      logic [WORD_W-1:0]     pos;
      track_t                t;
      frames++;
      slot = f.frame_id - base_id;
      if (slot >= MOTORS) begin
        foreign++;
        return;
      end
      m = slot;
      t = '0;
      t.motor_sel = m[MIDX_W-1:0];
      cal = frame_cnt[m] < cal_frames;
      if (frame_cnt[m] != CTR_MAX) frame_cnt[m]++;
      if (cal) begin
        zero_ofs[m]   = f.angle_raw;
        last_angle[m] = f.angle_raw;
        last_pos[m]   = WORD_W'(f.angle_raw);
        t.calibrating = 1'b1;
        cal_results++;
      end else begin
        t.speed = (f.speed_raw > SPEED_HALF) ? {1'b1, f.speed_raw} : {1'b0, f.speed_raw};
        diff = int'(f.angle_raw) - int'(last_angle[m]);
        if (diff > int'(TURN / 2)) begin
          turns[m]--;
          wraps++;
        end else if (diff < -int'(TURN / 2)) begin
          turns[m]++;
          wraps++;
        end
        last_angle[m] = f.angle_raw;
        pos = WORD_W'(f.angle_raw) + WORD_W'(TURN) * turns[m] - WORD_W'(zero_ofs[m]);
        if (ring_wr[m] >= DEPTH) ring_wr[m] = 0;
        deltas[m][ring_wr[m]] = DELTA_W'(pos - last_pos[m]);
        last_pos[m] = pos;
        ring_wr[m]++;
        if (ring_wr[m] == DEPTH) begin
          ring_wr[m] = 0;
          held_rate[m] = window_rate(m);
          windows++;
        end
        t.turn_count   = turns[m];
        t.position     = pos;
        t.angular_rate = held_rate[m];
      end
      expected_tracks.push_back(t);
    endfunction

    function void check_result(track_t got);
      track_t want;
      if (expected_tracks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: motor %0d cal %0b pos %0d", got.motor_sel,
                   got.calibrating, got.position);
        return;
      end
      want = expected_tracks.pop_front();
      checked++;
      if (got.motor_sel !== want.motor_sel || got.calibrating !== want.calibrating ||
          got.speed !== want.speed || got.turn_count !== want.turn_count ||
          got.position !== want.position || got.angular_rate !== want.angular_rate) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch exp: motor %0d cal %0b spd %0d turns %0d pos %0d rate %0d",
                   want.motor_sel, want.calibrating, want.speed, want.turn_count,
                   want.position, want.angular_rate);
          $display("         got: motor %0d cal %0b spd %0d turns %0d pos %0d rate %0d",
                   got.motor_sel, got.calibrating, got.speed, got.turn_count,
                   got.position, got.angular_rate);
        end
      end
    endfunction

    function int pending();
      return expected_tracks.size();
    endfunction

    // anything still owed at the end is a failure
    function void close();
      if (expected_tracks.size() != 0) begin
        $display("%0d results never arrived", expected_tracks.size());
        errors += expected_tracks.size();
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  metr_in_if  in_chan();
  metr_out_if out_chan();

  motor_encoder_feedback_tracker_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_chan    (in_chan),
    .out_chan   (out_chan)
  );

  tracker_scoreboard tracks;

  // idling knobs, set per phase by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // long receiver hold-off: stimulus bumps the request count, the ready process does the counting
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // current id base, used to aim random frames at motors
  logic [FRAME_ID_W-1:0] base_now;
  // per-motor encoder angle for the well-formed random motion
  int track_angle [MOTORS];
  int input_stalls = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result channel ready: random stalls, or a long hold-off when asked for
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_OFF_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // sample both channels at the rising edge; results are checked before new frames are noted
  always @(posedge clk_i) begin : watch
    track_t got;
    frame_t seen;
    if (rst_ni) begin
      if (out_chan.valid && out_chan.ready) begin
        got.motor_sel    = out_chan.motor_sel;
        got.calibrating  = out_chan.calibrating;
        got.speed        = out_chan.speed;
        got.turn_count   = out_chan.turn_count;
        got.position     = out_chan.position;
        got.angular_rate = out_chan.angular_rate;
        tracks.check_result(got);
      end
      if (in_chan.valid && in_chan.ready) begin
        seen.frame_id  = in_chan.frame_id;
        seen.angle_raw = in_chan.angle_raw;
        seen.speed_raw = in_chan.speed_raw;
        tracks.note_frame(seen);
      end else if (in_chan.valid) begin
        input_stalls++;
      end
    end
  end

  function automatic frame_t make_frame(int unsigned id, int unsigned ang, int unsigned spd);
    frame_t f;
    f.frame_id  = FRAME_ID_W'(id);
    f.angle_raw = ANGLE_W'(ang);
    f.speed_raw = ANGLE_W'(spd);
    return f;
  endfunction

  // mostly smooth encoder motion on a known motor, some wild angles and foreign ids
  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned m;
    int unsigned pick;
    int          step;
    pick = $urandom_range(99);
    f.speed_raw = ANGLE_W'($urandom);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: f.speed_raw = 16'h0000;
        1: f.speed_raw = 16'h7FFF;
        2: f.speed_raw = SPEED_HALF;
        3: f.speed_raw = 16'h8001;
        default: f.speed_raw = 16'hFFFF;
      endcase
    end
    if (pick < 10) begin
      // an id that maps to no motor
      f.frame_id  = base_now + FRAME_ID_W'(MOTORS + $urandom_range(2047 - MOTORS));
      f.angle_raw = ANGLE_W'($urandom);
      return f;
    end
    m = $urandom_range(MOTORS - 1);
    f.frame_id = base_now + FRAME_ID_W'(m);
    if (pick < 80) begin
      case ($urandom_range(19))
        0: step = $urandom_range(1) ? 4096 : -4096;
        1: step = $urandom_range(1) ? 4097 : -4097;
        2, 3: step = int'($urandom_range(8190)) - 4095;
        default: step = int'($urandom_range(600)) - 300;
      endcase
      track_angle[m] = (track_angle[m] + step + int'(TURN)) % int'(TURN);
      f.angle_raw = ANGLE_W'(track_angle[m]);
    end else begin
      f.angle_raw = ANGLE_W'($urandom);
      track_angle[m] = int'(f.angle_raw) % int'(TURN);
    end
    return f;
  endfunction

  // offers one request; valid stays high on return so back-to-back requests need no gap
  task automatic send_frame(frame_t f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_chan.valid     <= 1'b1;
    in_chan.frame_id  <= f.frame_id;
    in_chan.angle_raw <= f.angle_raw;
    in_chan.speed_raw <= f.speed_raw;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracks.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(logic [FRAME_ID_W-1:0] base, logic [CAL_W-1:0] cal,
                           logic [GAIN_W-1:0] gain);
    write_reg(CFG_BASE_ID, CFG_DATA_W'(base));
    write_reg(CFG_CAL_CNT, CFG_DATA_W'(cal));
    write_reg(CFG_GAIN, gain);
    base_now = base;
  endtask

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 54; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 54; end
      IDLE_BOTH:     begin send_idle_pct = 15; stall_pct = 15; end
      default:       begin send_idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // stop sending and wait until every owed result is in, then let any foreign-id work finish
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (tracks.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [FRAME_ID_W-1:0] base, logic [CAL_W-1:0] cal,
                           logic [GAIN_W-1:0] gain, idle_mode_e mode, int count,
                           bit pressure);
    configure(base, cal, gain);
    set_idling(mode);
    for (int i = 0; i < count; i++) begin
      // receiver goes deaf for a long stretch while frames keep coming
      if (pressure && i == 40) hold_reqs++;
      // sender holds back until the block has delivered everything
      if (pressure && i == 90) settle();
      send_frame(random_frame());
    end
    settle();
  endtask

  initial begin
    tracks = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_BASE_ID;
    cfg_wdata_i       = '0;
    in_chan.valid     = 1'b0;
    in_chan.frame_id  = '0;
    in_chan.angle_raw = '0;
    in_chan.speed_raw = '0;
    out_chan.ready    = 1'b0;
    base_now          = BASE_ID_RST;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part: two calibration frames per motor, gain at its top
    configure(11'd0, 6'd2, 16'hFFFF);
    set_idling(IDLE_NONE);
    // ids that hit no motor
    send_frame(make_frame(4, 16'hFFFF, 16'hFFFF));
    send_frame(make_frame(2047, 16'h0000, 16'h0000));
    // motor 0: calibration, then angle and speed extremes and both wrap directions
    send_frame(make_frame(0, 100, 1234));
    send_frame(make_frame(0, 200, 16'hFFFF));
    send_frame(make_frame(0, 0, 0));
    send_frame(make_frame(0, 16'hFFFF, 16'hFFFF));
    send_frame(make_frame(0, 0, SPEED_HALF));
    // half-turn boundary: a jump of exactly half a turn is not a wrap
    send_frame(make_frame(0, 4096, 16'h8001));
    send_frame(make_frame(0, 0, 16'h7FFF));
    send_frame(make_frame(0, 4097, 1));
    send_frame(make_frame(0, 0, 16'h8000));
    // motor 1: rolls over the top of a turn and back
    send_frame(make_frame(1, 8191, 7));
    send_frame(make_frame(1, 8191, 7));
    send_frame(make_frame(1, 10, 16'hFFFE));
    send_frame(make_frame(1, 8000, 2));
    // motors 2 and 3 with alternating bit patterns
    send_frame(make_frame(2, 16'h5555, 16'hAAAA));
    send_frame(make_frame(2, 16'hAAAA, 16'h5555));
    send_frame(make_frame(2, 16'hAAAA, 16'h5555));
    send_frame(make_frame(3, 16'hFFFF, 0));
    send_frame(make_frame(3, 16'h0000, 0));
    send_frame(make_frame(3, 16'h1234, 16'h8000));
    send_frame(make_frame(3, 16'hFFFF, 16'h8001));
    settle();

    // random part across register settings and idling patterns
    run_phase(11'd2047, 6'd0, 16'd0, IDLE_NONE, 120, 1'b0);
    run_phase(11'd2047, 6'd63, GAIN_RST, IDLE_SENDER, 130, 1'b0);
    run_phase(11'd1024, 6'd8, 16'hFFFF, IDLE_RECEIVER, 120, 1'b0);
    run_phase(BASE_ID_RST, CAL_CNT_RST, GAIN_RST, IDLE_NONE, 130, 1'b1);
    run_phase(11'h555, 6'd31, 16'd40000, IDLE_BOTH, 130, 1'b0);
    run_phase(11'h2AA, 6'd1, 16'd1, IDLE_RECEIVER, 120, 1'b0);

    tracks.close();
    $display("covered %0d frames (%0d with foreign ids) over seven register settings",
             tracks.frames, tracks.foreign);
    $display("%0d results checked, %0d calibrating, %0d rate windows, %0d wraps, %0d stalls",
             tracks.checked, tracks.cal_results, tracks.windows, tracks.wraps, input_stalls);
    if (tracks.errors == 0) begin
      $display("tb_motor_encoder_feedback_tracker_top: clean");
    end else begin
      $display("tb_motor_encoder_feedback_tracker_top: errors");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #1000000;
    $display("timeout with %0d results still owed", tracks.pending());
    $display("tb_motor_encoder_feedback_tracker_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/metr_pkg.sv
design/metr_if.sv
design/metr_ctrl.sv
design/metr_dp.sv
design/motor_encoder_feedback_tracker_top.sv
sim/tb_motor_encoder_feedback_tracker_top.sv
